// ===== rtl/core/lfcc_pkg.sv =====
package lfcc_pkg;
   localparam int NUM_CHUNKS_DEF = 8;
   localparam int AW = 31;
   localparam int CW = 32;
   localparam int IDXW = 3;
   localparam logic [AW-1:0] CHUNK_SIZE_RST = 31'd65536;
   localparam logic [AW-1:0] FILE_SIZE_RST = 31'd0;
   localparam logic [0:0] REG_CHUNK_SIZE = 1'b0;
   localparam logic [0:0] REG_FILE_SIZE = 1'b1;

   typedef struct packed {
      logic [AW-1:0] offset;
      logic [AW-1:0] length;
   } req_type;

   typedef struct packed {
      logic          valid_res;
      logic          hit;
      logic [IDXW-1:0] chunk_index;
      logic [AW-1:0] fill_start;
      logic [AW-1:0] fill_size;
      logic [AW-1:0] buffer_offset;
      logic [CW-1:0] hits_so_far;
      logic [CW-1:0] misses_so_far;
   } rsp_type;

   // descriptor as it travels around the ring
   typedef struct packed {
      logic [AW-1:0] start;
      logic [AW-1:0] len;
      logic [CW-1:0] last_use;
   } desc_type;

   // write-back into the descriptor at the ring head
   typedef struct packed {
      logic          wr_desc;
      logic          wr_stamp;
      desc_type      desc;
   } upd_type;
endpackage

// ===== rtl/core/lfcc_if.sv =====
interface lfcc_req_if;
   logic valid;
   logic ready;
   lfcc_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface lfcc_rsp_if;
   logic valid;
   logic ready;
   lfcc_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lfcc_cell.sv =====
// One descriptor slot of the rotating ring.
module lfcc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  lfcc_pkg::desc_type  d_in,
   output lfcc_pkg::desc_type  d_out
);
   lfcc_pkg::desc_type d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff <= '0;
      end else if (shift) begin
         d_ff <= d_in;
      end
   end

   assign d_out = d_ff;
endmodule

// ===== rtl/core/lfcc_ring.sv =====
// Ring of cells; head is cell 0. Rotated one per cycle on shift, a full
// turn shows each descriptor at head in index order and restores order.
module lfcc_ring #(
   parameter int NUM_CHUNKS = lfcc_pkg::NUM_CHUNKS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift,
   input  lfcc_pkg::upd_type   upd,
   output lfcc_pkg::desc_type  head
);
   lfcc_pkg::desc_type q [NUM_CHUNKS];
   lfcc_pkg::desc_type d [NUM_CHUNKS];
   lfcc_pkg::desc_type head_new;

   always_comb begin
      head_new = q[0];
      if (upd.wr_desc) begin
         head_new.start = upd.desc.start;
         head_new.len   = upd.desc.len;
      end
      if (upd.wr_stamp) head_new.last_use = upd.desc.last_use;
   end

   for (genvar i = 0; i < NUM_CHUNKS; i++) begin : g_cell
      if (i == NUM_CHUNKS - 1) begin : g_last
         assign d[i] = head_new;
      end else begin : g_mid
         assign d[i] = q[i+1];
      end
      lfcc_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift | upd.wr_desc | upd.wr_stamp),
         .d_in  ((NUM_CHUNKS == 1) ? head_new : d[i]),
         .d_out (q[i])
      );
   end

   assign head = q[0];
endmodule

// ===== rtl/core/lfcc_div.sv =====
// Restoring divider, one quotient bit per cycle; returns floor(n/d)*d.
module lfcc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lfcc_pkg::AW-1:0]    num,
   input  logic [lfcc_pkg::AW-1:0]    den,
   output logic                       done,
   output logic [lfcc_pkg::AW-1:0]    aligned
);
   localparam int AW = lfcc_pkg::AW;
   logic [AW-1:0] rem_ff, rem_in, quo_ff, quo_in, den_ff, num_ff;
   logic [AW:0]   trial;
   logic [4:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[AW-1]} - {1'b0, den_ff};
      if (start) begin
         rem_in = '0;
         quo_in = num;
         cnt_in = 5'(AW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[AW]) begin
            rem_in = trial[AW-1:0];
            quo_in = {quo_ff[AW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[AW-2:0], quo_ff[AW-1]};
            quo_in = {quo_ff[AW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         den_ff <= den;
         num_ff <= num;
      end
   end

   // offset - remainder is the aligned start
   assign done = done_ff;
   assign aligned = num_ff - rem_ff;
endmodule

// ===== rtl/core/lru_file_chunk_cache.sv =====
// A request runs a scan over all NUM_CHUNKS cells, then on a miss the divider,
// then a rotation that brings every cell past the head once. The result beat
// is held until taken; the next request beat can be taken in the cycle after
// it, and no request is accepted while one is in flight.
// The rate is set by the descriptor ring rotating one cell per cycle and the
// bit-serial alignment divider. Synchronous reset empties all chunks,
// clears counters and loads chunk_size 65536, file_size 0.
module lru_file_chunk_cache #(
   parameter int NUM_CHUNKS = lfcc_pkg::NUM_CHUNKS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   lfcc_req_if.sink                  req,
   lfcc_rsp_if.source                rsp,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [lfcc_pkg::AW-1:0]   csr_wdata
);
   localparam int AW = lfcc_pkg::AW;
   localparam int CW = lfcc_pkg::CW;
   localparam int IW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam int CNTW = $clog2(NUM_CHUNKS + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_DIV = 6'b000100,
      S_SEEK = 6'b001000, S_ROT = 6'b010000, S_OUT = 6'b100000
   } state_type;

   state_type st_ff, st_in;
   logic [AW-1:0] csize_ff, fsize_ff, off_ff, len_ff;
   logic [CW-1:0] use_ff, use_in, hits_ff, hits_in, miss_ff, miss_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [IW-1:0] fnd_ff, fnd_in, vic_ff, vic_in, idx_ff, idx_in;
   logic [CW-1:0] vuse_ff, vuse_in;
   logic hf_ff, hf_in;
   lfcc_pkg::rsp_type out_ff, out_in;
   lfcc_pkg::desc_type head;
   lfcc_pkg::upd_type upd;
   logic shift, div_start, div_done;
   logic [AW-1:0] aligned, den;
   logic [AW:0] dend, cend, ext_end, fill_end;
   logic [AW-1:0] fsz;
   logic holds_head, fit;
   logic [AW:0] head_end;

   assign den = (csize_ff == '0) ? AW'(1) : csize_ff;
   assign dend = {1'b0, off_ff} + {1'b0, len_ff};
   assign head_end = {1'b0, head.start} + {1'b0, head.len};
   assign holds_head = (head.start <= off_ff) && (dend <= head_end);

   // refill plan from the aligned start
   always_comb begin
      cend = {1'b0, aligned} + {1'b0, den};
      ext_end = (cend < dend) ? dend : cend;
      fill_end = (ext_end > {1'b0, fsize_ff}) ? {1'b0, fsize_ff} : ext_end;
      fsz = (fill_end > {1'b0, aligned}) ? AW'(fill_end - {1'b0, aligned}) : '0;
      fit = (aligned <= off_ff) && (dend <= {1'b0, aligned} + {1'b0, fsz});
   end

   lfcc_ring #(.NUM_CHUNKS(NUM_CHUNKS)) u_ring (
      .clock (clock), .reset (reset), .shift (shift), .upd (upd), .head (head)
   );

   lfcc_div u_div (
      .clock (clock), .reset (reset), .start (div_start), .num (off_ff),
      .den (den), .done (div_done), .aligned (aligned)
   );

   assign req.ready = (st_ff == S_IDLE);
   assign rsp.valid = (st_ff == S_OUT);
   assign rsp.data = out_ff;

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      fnd_in = fnd_ff;
      vic_in = vic_ff;
      vuse_in = vuse_ff;
      hf_in = hf_ff;
      idx_in = idx_ff;
      use_in = use_ff;
      hits_in = hits_ff;
      miss_in = miss_ff;
      out_in = out_ff;
      shift = 1'b0;
      div_start = 1'b0;
      upd = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (req.valid) begin
               st_in = S_SCAN;
               cnt_in = '0;
               hf_in = 1'b0;
            end
         end
         S_SCAN: begin
            // head holds descriptor number cnt
            shift = 1'b1;
            if (holds_head) begin
               hf_in = 1'b1;
               fnd_in = IW'(cnt_ff);
            end
            if (cnt_ff == '0 || head.len == '0 || head.last_use < vuse_ff) begin
               vic_in = IW'(cnt_ff);
               vuse_in = head.last_use;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NUM_CHUNKS - 1)) begin
               cnt_in = '0;
               if (hf_in) begin
                  hits_in = hits_ff + 1'b1;
                  idx_in = fnd_in;
                  st_in = S_SEEK;
               end else begin
                  miss_in = miss_ff + 1'b1;
                  idx_in = vic_in;
                  div_start = 1'b1;
                  st_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_done) st_in = S_SEEK;
         end
         S_SEEK: begin
            // rotate the target to the head, update it there, and finish the full turn
            if (cnt_ff == CNTW'(idx_ff)) begin
               if (hf_ff) begin
                  use_in = use_ff + 1'b1;
                  upd.wr_stamp = 1'b1;
                  upd.desc.last_use = use_in;
                  out_in.valid_res = 1'b1;
                  out_in.hit = 1'b1;
                  out_in.fill_start = '0;
                  out_in.fill_size = '0;
                  out_in.buffer_offset = off_ff - head.start;
               end else begin
                  upd.wr_desc = 1'b1;
                  upd.desc.start = aligned;
                  upd.desc.len = fsz;
                  out_in.valid_res = fit;
                  out_in.hit = 1'b0;
                  out_in.fill_start = aligned;
                  out_in.fill_size = fsz;
                  out_in.buffer_offset = fit ? off_ff - aligned : '0;
                  if (fit) begin
                     use_in = use_ff + 1'b1;
                     upd.wr_stamp = 1'b1;
                     upd.desc.last_use = use_in;
                  end
               end
               out_in.chunk_index = lfcc_pkg::IDXW'(idx_ff);
               out_in.hits_so_far = hits_ff;
               out_in.misses_so_far = miss_ff;
            end else begin
               shift = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(NUM_CHUNKS - 1)) st_in = S_OUT;
         end
         S_ROT: st_in = S_OUT;
         S_OUT: begin
            if (rsp.ready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         csize_ff <= lfcc_pkg::CHUNK_SIZE_RST;
         fsize_ff <= lfcc_pkg::FILE_SIZE_RST;
         use_ff <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
      end else begin
         st_ff <= st_in;
         use_ff <= use_in;
         hits_ff <= hits_in;
         miss_ff <= miss_in;
         if (csr_we) begin
            unique case (csr_index)
               lfcc_pkg::REG_CHUNK_SIZE: csize_ff <= csr_wdata;
               lfcc_pkg::REG_FILE_SIZE:  fsize_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
      if (st_ff == S_IDLE && req.valid) begin
         off_ff <= req.data.offset;
         len_ff <= req.data.length;
      end
      cnt_ff <= cnt_in;
      fnd_ff <= fnd_in;
      vic_ff <= vic_in;
      vuse_ff <= vuse_in;
      hf_ff <= hf_in;
      idx_ff <= idx_in;
      out_ff <= out_in;
   end
endmodule
